// ===== rtl/four_tap_fractional_interpolator_assert.svh =====
// Assertion macros for the four-tap fractional interpolator.
// Both macros sample on the rising edge of the enclosing module's clock.
`ifndef FOUR_TAP_FRACTIONAL_INTERPOLATOR_ASSERT_SVH
`define FOUR_TAP_FRACTIONAL_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define FTFI_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("four_tap_fractional_interpolator: assertion failed");

// The consequent must hold in the cycle after the antecedent, reset included.
`define FTFI_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("four_tap_fractional_interpolator: assertion failed");

`else

`define FTFI_ASSERT_IMPLY(name, ante, cons)

`define FTFI_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/ftfi_pkg.sv =====
`timescale 1ns / 1ps
package ftfi_pkg;

   localparam int FTFI_SAMPLE_BITS = 16;
   localparam int FTFI_FRAC_BITS   = 16;
   localparam int FTFI_MODE_W      = 3;

   localparam logic [FTFI_MODE_W-1:0] MODE_NONE    = 3'd0;
   localparam logic [FTFI_MODE_W-1:0] MODE_ROUND   = 3'd1;
   localparam logic [FTFI_MODE_W-1:0] MODE_LINEAR  = 3'd2;
   localparam logic [FTFI_MODE_W-1:0] MODE_KEYS    = 3'd3;
   localparam logic [FTFI_MODE_W-1:0] MODE_BSPLINE = 3'd4;
   localparam logic [FTFI_MODE_W-1:0] MODE_OMOMS   = 3'd5;
   localparam logic [FTFI_MODE_W-1:0] MODE_NNA     = 3'd6;
   localparam logic [FTFI_MODE_W-1:0] MODE_SCHAUM  = 3'd7;

   localparam logic [FTFI_MODE_W-1:0] MODE_RESET = MODE_LINEAR;

endpackage

// ===== rtl/ftfi_if.sv =====
`timescale 1ns / 1ps
interface ftfi_req_if import ftfi_pkg::*; #(
   parameter int SAMPLE_BITS = FTFI_SAMPLE_BITS,
   parameter int FRAC_BITS   = FTFI_FRAC_BITS
);
   logic                          valid;
   logic                          ready;
   logic [FRAC_BITS-1:0]          frac;
   logic signed [SAMPLE_BITS-1:0] sample_before;
   logic signed [SAMPLE_BITS-1:0] sample_center;
   logic signed [SAMPLE_BITS-1:0] sample_next;
   logic signed [SAMPLE_BITS-1:0] sample_after_next;

   modport source (output valid, frac, sample_before, sample_center, sample_next,
                   sample_after_next, input ready);
   modport sink (input valid, frac, sample_before, sample_center, sample_next,
                 sample_after_next, output ready);
endinterface

interface ftfi_rsp_if import ftfi_pkg::*; #(
   parameter int SAMPLE_BITS = FTFI_SAMPLE_BITS
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] value;
   logic                          clipped;

   modport source (output valid, value, clipped, input ready);
   modport sink (input valid, value, clipped, output ready);
endinterface

interface ftfi_csr_if import ftfi_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [FTFI_MODE_W-1:0] kernel_mode;

   modport source (output valid, kernel_mode, input ready);
   modport sink (input valid, kernel_mode, output ready);
endinterface

// ===== rtl/ftfi_div.sv =====
`timescale 1ns / 1ps
module ftfi_div import ftfi_pkg::*; #(
   parameter int DEN_W = 8,
   parameter int QUO_W = 8
) (
   input  logic                   clock,
   input  logic                   adv,
   input  logic [DEN_W+QUO_W-1:0] num,
   input  logic [DEN_W-1:0]       den,
   output logic [QUO_W-1:0]       quo
);

   // Restoring division, one quotient bit per stage. The caller guarantees
   // that the numerator's upper DEN_W bits are below the divisor.

   logic [DEN_W-1:0] rem_ff [QUO_W-1];
   logic [DEN_W-1:0] den_ff [QUO_W-1];
   logic [QUO_W-1:0] low_ff [QUO_W-1];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [DEN_W:0]   step_in [QUO_W];

   function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                               input logic nbit,
                                               input logic [DEN_W-1:0] d);
      logic [DEN_W:0] trial;
      logic           take;
      trial = {rem, nbit};
      take  = trial >= {1'b0, d};
      if (take) begin
         trial = trial - {1'b0, d};
      end
      return {take, trial[DEN_W-1:0]};
   endfunction

   always_comb begin
      step_in[0] = div_step(num[DEN_W+QUO_W-1:QUO_W], num[QUO_W-1], den);
      for (int k = 1; k < QUO_W; k++) begin
         step_in[k] = div_step(rem_ff[k-1], low_ff[k-1][QUO_W-1], den_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= step_in[0][DEN_W-1:0];
         den_ff[0] <= den;
         low_ff[0] <= {num[QUO_W-2:0], 1'b0};
         quo_ff[0] <= {{(QUO_W-1){1'b0}}, step_in[0][DEN_W]};
         for (int k = 1; k < QUO_W - 1; k++) begin
            rem_ff[k] <= step_in[k][DEN_W-1:0];
            den_ff[k] <= den_ff[k-1];
            low_ff[k] <= {low_ff[k-1][QUO_W-2:0], 1'b0};
         end
         for (int k = 1; k < QUO_W; k++) begin
            quo_ff[k] <= {quo_ff[k-1][QUO_W-2:0], step_in[k][DEN_W]};
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

// ===== rtl/ftfi_delay.sv =====
`timescale 1ns / 1ps
module ftfi_delay import ftfi_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             valid_in,
   input  logic [WIDTH-1:0] data_in,
   output logic             valid_out,
   output logic [WIDTH-1:0] data_out
);

   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] data_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DEPTH-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff[0] <= data_in;
         for (int k = 1; k < DEPTH; k++) begin
            data_ff[k] <= data_ff[k-1];
         end
      end
   end

   assign valid_out = valid_ff[DEPTH-1];
   assign data_out  = data_ff[DEPTH-1];

endmodule

// ===== rtl/four_tap_fractional_interpolator.sv =====
// Throughput: one beat per cycle; every stage advances together, so the whole
// pipeline holds while a result waits on rsp_bus with ready low.
// The depth is set by the two chained banks of bit-per-stage dividers of the NNA weights.
// Reset (synchronous, active high) empties the pipeline and sets kernel_mode
// to linear.
`timescale 1ns / 1ps
`include "four_tap_fractional_interpolator_assert.svh"
module four_tap_fractional_interpolator import ftfi_pkg::*; #(
   parameter int SAMPLE_BITS = FTFI_SAMPLE_BITS,
   parameter int FRAC_BITS   = FTFI_FRAC_BITS
) (
   input logic     clock,
   input logic     reset,
   ftfi_req_if.sink req_bus,
   ftfi_rsp_if.source rsp_bus,
   ftfi_csr_if.sink csr_bus
);

   localparam int S      = SAMPLE_BITS;
   localparam int F      = FRAC_BITS;
   localparam int FSQW   = 2 * F;
   localparam int DW     = F + 2;
   localparam int DSQW   = 2 * DW;
   localparam int QW     = F + 3;
   localparam int QSQW   = 2 * QW;
   localparam int UW     = F + 5;
   localparam int Q1     = 63 - F;
   localparam int SUMW   = Q1 + 2;
   localparam int N2W    = SUMW + F + 1;
   localparam int WQ     = F + 1;
   localparam int WW     = F + 4;
   localparam int PW     = WW + S;
   localparam int AW     = PW + 2;
   localparam int TW     = S + 6;
   localparam int OW     = S + 2;
   localparam int MWD    = S + 3;
   localparam int KD     = S + 4;
   localparam int SIDE_W = 1 + 4 * S + 4 * WW;
   localparam int DLY    = Q1 + 3 + WQ;

   localparam logic [F-1:0]    F_HALF   = {1'b1, {(F-1){1'b0}}};
   localparam logic [FSQW-1:0] FSQ_HALF = FSQW'(F_HALF);
   localparam logic [DSQW-1:0] DSQ_HALF = DSQW'(F_HALF);
   localparam logic [QSQW-1:0] QSQ_HALF = QSQW'(F_HALF);
   localparam logic [DW-1:0]   D_ONE    = DW'(1) << F;
   localparam logic [DW-1:0]   D_TWO    = DW'(1) << (F + 1);
   localparam logic [UW+Q1-1:0] INV_NUM = (UW + Q1)'(1) << (Q1 - 1);

   localparam logic signed [WW-1:0] W_ONE  = WW'(1) << F;
   localparam logic signed [WW-1:0] W_HALF = WW'(1) << (F - 1);
   localparam logic signed [AW-1:0] A_HALF = AW'(1) << (F - 1);
   localparam logic signed [AW-1:0] A_ONE  = AW'(1) << F;
   localparam logic signed [AW-1:0] A_3ONE = A_ONE + A_ONE + A_ONE;

   localparam logic signed [S-1:0]  SAT_MAX  = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0]  SAT_MIN  = {1'b1, {(S-1){1'b0}}};
   localparam logic signed [TW-1:0] T_MAX    = TW'(SAT_MAX);
   localparam logic signed [TW-1:0] T_MIN    = TW'(SAT_MIN);
   localparam logic signed [TW-1:0] T_TWO    = TW'(2);
   localparam logic signed [TW-1:0] T3_MIN   = T_MIN + T_MIN + T_MIN;
   localparam logic signed [TW-1:0] T3_MAXP2 = T_MAX + T_MAX + T_MAX + T_TWO;
   localparam logic [MWD-1:0] DIV3_RECIP = MWD'(((64'd1 << KD) + 64'd2) / 64'd3);

   logic adv;
   logic [FTFI_MODE_W-1:0] kernel_mode_ff;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic m1_valid_ff, m2_valid_ff, m3_valid_ff, m4_valid_ff, out_valid_ff;

   logic [F-1:0] s1_x_ff, s2_x_ff, s3_x_ff, s4_x_ff;
   logic         s1_zero_ff, s2_zero_ff, s3_zero_ff, s4_zero_ff;
   logic signed [S-1:0] s1_samp_ff [4];
   logic signed [S-1:0] s2_samp_ff [4];
   logic signed [S-1:0] s3_samp_ff [4];
   logic signed [S-1:0] s4_samp_ff [4];
   logic [FSQW-1:0] s1_xsq_ff, s3_x2x_ff;
   logic [F-1:0]    s2_x2_ff, s3_x2_ff, s4_x2_ff, s4_x3_ff;
   logic [DSQW-1:0] s1_dsq_ff [4];
   logic [QW-1:0]   s2_q_ff [4];
   logic [QSQW-1:0] s3_qsq_ff [4];
   logic [UW-1:0]   s4_u_ff [4];
   logic [UW-1:0]   u_raw [4];
   logic [DW-1:0]   tap_dist [4];

   logic signed [WW-1:0] w_in [4];
   logic [SIDE_W-1:0]    side_in, side_out;
   logic                 side_valid;

   logic [Q1-1:0]   inv [4];
   logic [Q1-1:0]   p1_inv_ff [4];
   logic [Q1-1:0]   p2_inv_ff [4];
   logic [Q1:0]     p1_pair_ff [2];
   logic [SUMW-1:0] p2_sum_ff, p3_sum_ff;
   logic [N2W-1:0]  p3_num_ff [4];
   logic [WQ-1:0]   wn [4];

   logic signed [WW-1:0] w_sel [4];
   logic signed [PW-1:0] m1_prod_ff [4];
   logic signed [AW-1:0] m2_acc_ff;
   logic signed [AW-1:0] rnd_sum;
   logic signed [TW-1:0] m3_t_ff, t_off;
   logic [OW+MWD-1:0]    m4_q3_ff;
   logic [S-1:0]         m4_tlow_ff, q3;
   logic                 m4_hi_ff, m4_lo_ff;
   logic                 m1_zero_ff, m2_zero_ff, m3_zero_ff, m4_zero_ff;
   logic signed [S-1:0]  m1_ctr_ff, m2_ctr_ff, m3_ctr_ff, m4_ctr_ff;
   logic signed [S-1:0]  out_value_ff, value_in;
   logic                 out_clip_ff, clip_in;
   logic                 is_schaum, is_nna, is_keys;
   logic                 rsp_at_limit;

   assign adv           = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign csr_bus.ready = 1'b1;

   assign is_schaum = kernel_mode_ff == MODE_SCHAUM;
   assign is_nna    = kernel_mode_ff == MODE_NNA;
   assign is_keys   = kernel_mode_ff == MODE_KEYS || kernel_mode_ff == MODE_BSPLINE ||
                      kernel_mode_ff == MODE_OMOMS;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_mode_ff <= MODE_RESET;
      end else if (csr_bus.valid) begin
         kernel_mode_ff <= csr_bus.kernel_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         m3_valid_ff  <= 1'b0;
         m4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_bus.valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         m1_valid_ff  <= side_valid;
         m2_valid_ff  <= m1_valid_ff;
         m3_valid_ff  <= m2_valid_ff;
         m4_valid_ff  <= m3_valid_ff;
         out_valid_ff <= m4_valid_ff;
      end
   end

   // Distances from the output position to the four taps, for NNA.
   always_comb begin
      tap_dist[0] = D_ONE + DW'(req_bus.frac);
      tap_dist[1] = DW'(req_bus.frac);
      tap_dist[2] = D_ONE - DW'(req_bus.frac);
      tap_dist[3] = D_TWO - DW'(req_bus.frac);
   end

   // Powers of the fraction and fourth powers of the distances.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x_ff       <= req_bus.frac;
         s1_zero_ff    <= req_bus.frac == '0;
         s1_samp_ff[0] <= req_bus.sample_before;
         s1_samp_ff[1] <= req_bus.sample_center;
         s1_samp_ff[2] <= req_bus.sample_next;
         s1_samp_ff[3] <= req_bus.sample_after_next;
         s1_xsq_ff     <= FSQW'(req_bus.frac) * FSQW'(req_bus.frac);
         for (int i = 0; i < 4; i++) begin
            s1_dsq_ff[i] <= DSQW'(tap_dist[i]) * DSQW'(tap_dist[i]);
         end

         s2_x_ff    <= s1_x_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_samp_ff <= s1_samp_ff;
         s2_x2_ff   <= F'((s1_xsq_ff + FSQ_HALF) >> F);
         for (int i = 0; i < 4; i++) begin
            s2_q_ff[i] <= QW'((s1_dsq_ff[i] + DSQ_HALF) >> F);
         end

         s3_x_ff    <= s2_x_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_samp_ff <= s2_samp_ff;
         s3_x2_ff   <= s2_x2_ff;
         s3_x2x_ff  <= FSQW'(s2_x2_ff) * FSQW'(s2_x_ff);
         for (int i = 0; i < 4; i++) begin
            s3_qsq_ff[i] <= QSQW'(s2_q_ff[i]) * QSQW'(s2_q_ff[i]);
         end

         s4_x_ff    <= s3_x_ff;
         s4_zero_ff <= s3_zero_ff;
         s4_samp_ff <= s3_samp_ff;
         s4_x2_ff   <= s3_x2_ff;
         s4_x3_ff   <= F'((s3_x2x_ff + FSQ_HALF) >> F);
         for (int i = 0; i < 4; i++) begin
            s4_u_ff[i] <= (u_raw[i] == '0) ? UW'(1) : u_raw[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         u_raw[i] = UW'((s3_qsq_ff[i] + QSQ_HALF) >> F);
      end
   end

   // Polynomial kernel weights. Keys weights are over two, Schaum over six.
   always_comb begin
      logic signed [WW-1:0] xs, x2s, x3s, tk;
      xs  = signed'(WW'(s4_x_ff));
      x2s = signed'(WW'(s4_x2_ff));
      x3s = signed'(WW'(s4_x3_ff));
      for (int i = 0; i < 4; i++) begin
         w_in[i] = '0;
      end
      tk = '0;
      case (kernel_mode_ff)
         MODE_ROUND: begin
            if (s4_x_ff < F_HALF) begin
               w_in[1] = W_ONE;
            end else if (s4_x_ff > F_HALF) begin
               w_in[2] = W_ONE;
            end else begin
               w_in[1] = W_HALF;
               w_in[2] = W_HALF;
            end
         end
         MODE_LINEAR: begin
            w_in[1] = W_ONE - xs;
            w_in[2] = xs;
         end
         MODE_KEYS, MODE_BSPLINE, MODE_OMOMS: begin
            w_in[0] = x2s + x2s - xs - x3s;
            w_in[1] = W_ONE + W_ONE - (x2s + x2s + x2s + x2s + x2s) + (x3s + x3s + x3s);
            w_in[2] = xs + (x2s + x2s + x2s + x2s) - (x3s + x3s + x3s);
            w_in[3] = x3s - x2s;
         end
         MODE_SCHAUM: begin
            w_in[0] = (x2s + x2s + x2s) - x3s - (xs + xs);
            tk      = x3s - (x2s + x2s) - xs + W_ONE + W_ONE;
            w_in[1] = tk + tk + tk;
            tk      = x3s - x2s - (xs + xs);
            w_in[2] = -(tk + tk + tk);
            w_in[3] = x3s - xs;
         end
         default: begin
            w_in[0] = '0;
         end
      endcase
   end

   always_comb begin
      side_in = '0;
      side_in[SIDE_W-1] = s4_zero_ff;
      for (int i = 0; i < 4; i++) begin
         side_in[i*WW +: WW]          = w_in[i];
         side_in[4*WW + i*S +: S]     = s4_samp_ff[i];
      end
   end

   ftfi_delay #(
      .WIDTH (SIDE_W),
      .DEPTH (DLY)
   ) u_side (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_in  (s4_valid_ff),
      .data_in   (side_in),
      .valid_out (side_valid),
      .data_out  (side_out)
   );

   // NNA: reciprocal fourth powers, their sum, then normalized weights.
   for (genvar g = 0; g < 4; g++) begin : g_inv
      ftfi_div #(
         .DEN_W (UW),
         .QUO_W (Q1)
      ) u_inv (
         .clock (clock),
         .adv   (adv),
         .num   (INV_NUM),
         .den   (s4_u_ff[g]),
         .quo   (inv[g])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_inv_ff     <= inv;
         p1_pair_ff[0] <= (Q1 + 1)'(inv[0]) + (Q1 + 1)'(inv[1]);
         p1_pair_ff[1] <= (Q1 + 1)'(inv[2]) + (Q1 + 1)'(inv[3]);
         p2_inv_ff     <= p1_inv_ff;
         p2_sum_ff     <= SUMW'(p1_pair_ff[0]) + SUMW'(p1_pair_ff[1]);
         p3_sum_ff     <= p2_sum_ff;
         for (int i = 0; i < 4; i++) begin
            p3_num_ff[i] <= (N2W'(p2_inv_ff[i]) << F) + N2W'(p2_sum_ff >> 1);
         end
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_wn
      ftfi_div #(
         .DEN_W (SUMW),
         .QUO_W (WQ)
      ) u_wn (
         .clock (clock),
         .adv   (adv),
         .num   (p3_num_ff[g]),
         .den   (p3_sum_ff),
         .quo   (wn[g])
      );
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         w_sel[i] = is_nna ? signed'(WW'(wn[i])) : signed'(side_out[i*WW +: WW]);
      end
   end

   always_comb begin
      if (is_schaum) begin
         rnd_sum = m2_acc_ff + A_3ONE;
      end else if (is_keys) begin
         rnd_sum = m2_acc_ff + A_ONE;
      end else begin
         rnd_sum = m2_acc_ff + A_HALF;
      end
   end

   // Schaum divides t by three: t is offset to be nonnegative, then scaled by
   // a reciprocal. Out-of-range t saturates and never uses this quotient.
   assign t_off = m3_t_ff - T3_MIN;
   assign q3    = m4_q3_ff[KD +: S];

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_zero_ff <= side_out[SIDE_W-1];
         m1_ctr_ff  <= signed'(side_out[4*WW + S +: S]);
         for (int i = 0; i < 4; i++) begin
            m1_prod_ff[i] <= PW'(w_sel[i]) * PW'(signed'(side_out[4*WW + i*S +: S]));
         end

         m2_zero_ff <= m1_zero_ff;
         m2_ctr_ff  <= m1_ctr_ff;
         m2_acc_ff  <= AW'(m1_prod_ff[0]) + AW'(m1_prod_ff[1]) +
                       AW'(m1_prod_ff[2]) + AW'(m1_prod_ff[3]);

         m3_zero_ff <= m2_zero_ff;
         m3_ctr_ff  <= m2_ctr_ff;
         if (is_schaum || is_keys) begin
            m3_t_ff <= TW'(rnd_sum >>> (F + 1));
         end else begin
            m3_t_ff <= TW'(rnd_sum >>> F);
         end

         m4_zero_ff <= m3_zero_ff;
         m4_ctr_ff  <= m3_ctr_ff;
         m4_tlow_ff <= m3_t_ff[S-1:0];
         m4_q3_ff   <= (OW + MWD)'(t_off[OW-1:0]) * (OW + MWD)'(DIV3_RECIP);
         if (is_schaum) begin
            m4_hi_ff <= m3_t_ff > T3_MAXP2;
            m4_lo_ff <= m3_t_ff < T3_MIN;
         end else begin
            m4_hi_ff <= m3_t_ff > T_MAX;
            m4_lo_ff <= m3_t_ff < T_MIN;
         end

         out_value_ff <= value_in;
         out_clip_ff  <= clip_in;
      end
   end

   always_comb begin
      value_in = '0;
      clip_in  = 1'b0;
      if (m4_zero_ff) begin
         value_in = m4_ctr_ff;
      end else if (kernel_mode_ff == MODE_NONE) begin
         value_in = '0;
      end else if (m4_hi_ff) begin
         value_in = SAT_MAX;
         clip_in  = 1'b1;
      end else if (m4_lo_ff) begin
         value_in = SAT_MIN;
         clip_in  = 1'b1;
      end else if (is_schaum) begin
         // Undo the offset of three times the lower limit.
         value_in = signed'({~q3[S-1], q3[S-2:0]});
      end else begin
         value_in = signed'(m4_tlow_ff);
      end
   end

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.value   = out_value_ff;
   assign rsp_bus.clipped = out_clip_ff;

   assign rsp_at_limit = rsp_bus.value == SAT_MAX || rsp_bus.value == SAT_MIN;

   `FTFI_ASSERT_IMPLY(a_clip_at_limit, rsp_bus.valid && rsp_bus.clipped, rsp_at_limit)
   `FTFI_ASSERT_IMPLY(a_stall_blocks_input, rsp_bus.valid && !rsp_bus.ready, !req_bus.ready)
   `FTFI_ASSERT_NEXT(a_reset_empties, reset, !rsp_bus.valid)

endmodule

// ===== dv/four_tap_fractional_interpolator_tb.sv =====
`timescale 1ns / 1ps
module four_tap_fractional_interpolator_tb;
   import ftfi_pkg::*;

   typedef struct {
      logic [FTFI_FRAC_BITS-1:0]          frac;
      logic signed [FTFI_SAMPLE_BITS-1:0] tap [4];
   } interp_point_type;

   typedef struct {
      logic signed [FTFI_SAMPLE_BITS-1:0] value;
      logic                               clipped;
   } interp_result_type;

   localparam int     PIPE_LATENCY = 76;
   localparam int     STALL_LIMIT  = 3000;
   localparam longint SAT_MAX      = 32767;
   localparam longint SAT_MIN      = -32768;

   logic clock;
   logic reset;

   ftfi_req_if req_bus ();
   ftfi_rsp_if rsp_bus ();
   ftfi_csr_if csr_bus ();

   four_tap_fractional_interpolator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   interp_result_type      pending_results [$];
   logic [FTFI_MODE_W-1:0] active_mode;
   int                     mismatch_count;
   int                     idle_cycles;
   int                     hold_off_cycles;
   bit                     receiver_eager;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint round_div(longint num, longint den);
      longint t;
      t = num + den / 2;
      if (t >= 0) return t / den;
      return -((-t + den - 1) / den);
   endfunction

   function automatic longint unsigned square_q(longint unsigned a);
      return (a * a + 64'd32768) >> 16;
   endfunction

   function automatic interp_result_type interpolate(logic [FTFI_MODE_W-1:0] mode,
                                                     interp_point_type pt);
      interp_result_type res;
      longint x, x2, x3, den, acc, r;
      longint w [4];
      longint unsigned tap_dist [4];
      longint unsigned inv [4];
      longint unsigned u, total;
      res.clipped = 1'b0;
      res.value = '0;
      x = pt.frac;
      x2 = (x * x + 32768) >>> 16;
      x3 = (x2 * x + 32768) >>> 16;
      if (pt.frac == 0) begin
         res.value = pt.tap[1];
         return res;
      end
      for (int i = 0; i < 4; i++) w[i] = 0;
      den = 65536;
      case (mode)
         MODE_ROUND: begin
            if (x < 32768) w[1] = 65536;
            else if (x > 32768) w[2] = 65536;
            else begin
               w[1] = 32768;
               w[2] = 32768;
            end
         end
         MODE_LINEAR: begin
            w[1] = 65536 - x;
            w[2] = x;
         end
         MODE_KEYS, MODE_BSPLINE, MODE_OMOMS: begin
            w[0] = -x + 2 * x2 - x3;
            w[1] = 2 * 65536 - 5 * x2 + 3 * x3;
            w[2] = x + 4 * x2 - 3 * x3;
            w[3] = x3 - x2;
            den = 2 * 65536;
         end
         MODE_SCHAUM: begin
            w[0] = -(x3 - 3 * x2 + 2 * x);
            w[1] = 3 * (x3 - 2 * x2 - x + 2 * 65536);
            w[2] = -3 * (x3 - x2 - 2 * x);
            w[3] = x3 - x;
            den = 6 * 65536;
         end
         MODE_NNA: begin
            tap_dist[0] = 65536 + x;
            tap_dist[1] = x;
            tap_dist[2] = 65536 - x;
            tap_dist[3] = 2 * 65536 - x;
            total = 0;
            for (int i = 0; i < 4; i++) begin
               u = square_q(square_q(tap_dist[i]));
               // A distance this close to zero would blow up the inverse weight.
               if (u == 0) u = 1;
               inv[i] = (64'd1 << 46) / u;
               total += inv[i];
            end
            for (int i = 0; i < 4; i++)
               w[i] = longint'((inv[i] * 64'd65536 + total / 2) / total);
         end
         default: return res;
      endcase
      acc = 0;
      for (int i = 0; i < 4; i++) acc += w[i] * longint'(pt.tap[i]);
      r = round_div(acc, den);
      if (r > SAT_MAX) begin
         r = SAT_MAX;
         res.clipped = 1'b1;
      end
      if (r < SAT_MIN) begin
         r = SAT_MIN;
         res.clipped = 1'b1;
      end
      res.value = r[FTFI_SAMPLE_BITS-1:0];
      return res;
   endfunction

   task automatic send_point(interp_point_type pt, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.frac <= pt.frac;
      req_bus.sample_before <= pt.tap[0];
      req_bus.sample_center <= pt.tap[1];
      req_bus.sample_next <= pt.tap[2];
      req_bus.sample_after_next <= pt.tap[3];
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(interpolate(active_mode, pt));
   endtask

   task automatic write_mode(logic [FTFI_MODE_W-1:0] mode);
      req_bus.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.kernel_mode <= mode;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      active_mode = mode;
   endtask

   function automatic interp_point_type make_point(int frac, int a, int b, int c, int d);
      interp_point_type pt;
      pt.frac = 16'(frac);
      pt.tap[0] = 16'(a);
      pt.tap[1] = 16'(b);
      pt.tap[2] = 16'(c);
      pt.tap[3] = 16'(d);
      return pt;
   endfunction

   function automatic logic signed [15:0] random_sample();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic interp_point_type random_point();
      interp_point_type pt;
      logic signed [15:0] base;
      case ($urandom_range(0, 7))
         0: pt.frac = 16'($urandom_range(0, 15));
         1: pt.frac = 16'hffff - 16'($urandom_range(0, 15));
         2: pt.frac = 16'(32'h8000 + $urandom_range(0, 2) - 1);
         default: pt.frac = 16'($urandom);
      endcase
      if ($urandom_range(0, 3) == 0) begin
         // A smooth run of samples, the usual case in real resampling.
         base = 16'($urandom);
         for (int i = 0; i < 4; i++)
            pt.tap[i] = 16'(int'(base) + int'($urandom_range(0, 2000)) - 1000);
      end else begin
         for (int i = 0; i < 4; i++) pt.tap[i] = random_sample();
      end
      return pt;
   endfunction

   task automatic test_zero_fraction();
      write_mode(MODE_NONE);
      send_point(make_point(0, -32768, 32767, -32768, 32767));
      send_point(make_point(0, 0, -32768, 0, 0));
      send_point(make_point(1, 32767, 32767, 32767, 32767));
      write_mode(MODE_NNA);
      send_point(make_point(0, 1, -5, 7, 9));
   endtask

   task automatic test_each_kernel();
      for (int m = 0; m < 8; m++) begin
         write_mode(m[FTFI_MODE_W-1:0]);
         send_point(make_point(16'h0001, -32768, 32767, -32768, 32767));
         send_point(make_point(16'h8000, -32768, 32767, 32767, -32768));
         send_point(make_point(16'hffff, 32767, -32768, 32767, -32768));
      end
   endtask

   task automatic test_backpressure();
      write_mode(MODE_KEYS);
      hold_off_cycles = 400;
      for (int i = 0; i < 120; i++) send_point(random_point(), 1);
   endtask

   task automatic test_random();
      logic [FTFI_MODE_W-1:0] order [10];
      order = '{MODE_LINEAR, MODE_KEYS, MODE_NNA, MODE_SCHAUM, MODE_ROUND,
                MODE_NONE, MODE_BSPLINE, MODE_OMOMS, MODE_NNA, MODE_SCHAUM};
      for (int p = 0; p < 10; p++) begin
         write_mode(order[p]);
         receiver_eager = (p % 3 == 2);
         for (int i = 0; i < 35; i++) send_point(random_point(), receiver_eager);
      end
      receiver_eager = 0;
   endtask

   // Receiver: random stalls, one long hold-off on request, checks every beat.
   initial begin
      interp_result_type want;
      int gap;
      rsp_bus.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off_cycles > 0) gap = hold_off_cycles;
         else gap = receiver_eager ? 0 : $urandom_range(0, 8);
         hold_off_cycles = 0;
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat: value=%0d clipped=%0b",
                        rsp_bus.value, rsp_bus.clipped);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.value !== want.value || rsp_bus.clipped !== want.clipped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected value=%0d clipped=%0b, got %0d %0b",
                           want.value, want.clipped, rsp_bus.value, rsp_bus.clipped);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      mismatch_count = 0;
      idle_cycles = 0;
      hold_off_cycles = 0;
      receiver_eager = 0;
      active_mode = MODE_RESET;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.frac <= '0;
      req_bus.sample_before <= '0;
      req_bus.sample_center <= '0;
      req_bus.sample_next <= '0;
      req_bus.sample_after_next <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.kernel_mode <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The first beat runs under the reset mode, before any register write.
      send_point(make_point(16'h4000, 100, -200, 300, -400));
      test_zero_fraction();
      test_each_kernel();
      test_backpressure();
      test_random();
      req_bus.valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (PIPE_LATENCY + 20) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
